@@ design/retry_backoff_controller_core_macros.svh @@
// Assertion macros shared by the retry backoff controller RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RETRY_BACKOFF_CONTROLLER_CORE_MACROS_SVH
`define RETRY_BACKOFF_CONTROLLER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RBC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rbc_pkg.sv @@
// Types and constants for the retry backoff controller.
// No dependencies; imported by retry_backoff_controller_core.
package rbc_pkg;

    typedef enum logic [2:0] {
        KIND_TRIGGER = 3'd0,
        KIND_OUTCOME = 3'd1,
        KIND_TICK    = 3'd2,
        KIND_STOP    = 3'd3,
        KIND_RESET   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_ATTEMPT = 3'd1,
        EV_SUCCESS = 3'd2,
        EV_GAVE_UP = 3'd3,
        EV_WAITING = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        CFG_RETRY_ENABLE = 3'd0,
        CFG_RETRY_LIMIT  = 3'd1,
        CFG_FIRST_DELAY  = 3'd2,
        CFG_DELAY_CAP    = 3'd3,
        CFG_GROWTH       = 3'd4
    } cfg_index_t;

    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned DELAY_W  = 32;
    localparam int unsigned LIMIT_W  = 17;
    localparam int unsigned GROWTH_W = 12;
    localparam int unsigned FRAC_W   = 8;

    localparam logic                RST_RETRY_ENABLE = 1'b1;
    localparam logic [LIMIT_W-1:0]  RST_RETRY_LIMIT  = 17'd5;
    localparam logic [DELAY_W-1:0]  RST_FIRST_DELAY  = 32'd1000;
    localparam logic [DELAY_W-1:0]  RST_DELAY_CAP    = 32'd30000;
    localparam logic [GROWTH_W-1:0] RST_GROWTH       = 12'd512;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

@@ design/retry_backoff_controller_core.sv @@
// Retry controller with capped exponential backoff, top level.
// Depends on rbc_pkg and retry_backoff_controller_core_macros.svh.
//
// Usage:
// The slave stream carries one command transaction per beat: s_tuser holds the
// kind (trigger, attempt outcome, tick, stop, reset) and s_tdata[0] the outcome
// flag. Every accepted transaction produces exactly one result transaction on
// the master stream: m_tuser holds the event code, m_tdata the attempt count,
// the wait length in ticks and the busy flag.
// The block holds one input register and one output register. A command is
// evaluated against the controller state once it is in the input register and
// the output register is free or being emptied. Throughput is one transaction
// per cycle while the receiver does not stall, since each command needs one
// pass through a 32 by 12 bit multiply, a clamp compare and the limit compare.
// When the receiver stalls, the result waits in the output register and the
// input register still takes one more command; the slave side then deasserts
// s_tready until the result is taken.
// Configuration is written through cfg_we, cfg_addr and cfg_wdata while the
// block is idle. Reset clears the run state and loads the register defaults.
`include "retry_backoff_controller_core_macros.svh"

module retry_backoff_controller_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] attempt_ok, [7:1] zero
    input  logic [2:0]  s_tuser,   // [2:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [15:0] attempt_number, [47:16] wait_ms, [48] busy_res
    output logic [2:0]  m_tuser    // [2:0] event_res
);

    import rbc_pkg::*;

    logic                retry_enable_reg;
    logic [LIMIT_W-1:0]  retry_limit_reg;
    logic [DELAY_W-1:0]  first_delay_reg;
    logic [DELAY_W-1:0]  delay_cap_reg;
    logic [GROWTH_W-1:0] growth_reg;

    logic                in_valid_reg;
    logic [2:0]          in_kind_reg;
    logic                in_ok_reg;

    logic                run_active_reg, run_active_next;
    logic                halted_reg, halted_next;
    logic                awaiting_reg, awaiting_next;
    logic [COUNT_W-1:0]  attempts_reg, attempts_next;
    logic [DELAY_W-1:0]  next_delay_reg, next_delay_next;
    logic [DELAY_W-1:0]  wait_left_reg, wait_left_next;

    logic                out_valid_reg, out_valid_next;
    event_t              out_event_reg, out_event_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic [DELAY_W-1:0]  out_wait_reg, out_wait_next;
    logic                out_busy_reg;

    logic                advance;
    logic                unlimited;
    logic [COUNT_W-1:0]  limit_count;
    logic                limit_hit;
    logic [DELAY_W+GROWTH_W-1:0] product;
    logic [DELAY_W+GROWTH_W-FRAC_W-1:0] grown;
    logic [DELAY_W-1:0]  grown_clamped;
    logic [DELAY_W-1:0]  wait_dec;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_enable_reg <= RST_RETRY_ENABLE;
            retry_limit_reg  <= RST_RETRY_LIMIT;
            first_delay_reg  <= RST_FIRST_DELAY;
            delay_cap_reg    <= RST_DELAY_CAP;
            growth_reg       <= RST_GROWTH;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_RETRY_ENABLE: retry_enable_reg <= cfg_wdata[0];
                CFG_RETRY_LIMIT:  retry_limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                CFG_FIRST_DELAY:  first_delay_reg  <= cfg_wdata[DELAY_W-1:0];
                CFG_DELAY_CAP:    delay_cap_reg    <= cfg_wdata[DELAY_W-1:0];
                CFG_GROWTH:       growth_reg       <= cfg_wdata[GROWTH_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= s_tuser;
            in_ok_reg   <= s_tdata[0];
        end
    end

    assign unlimited     = retry_limit_reg[LIMIT_W-1];
    assign limit_count   = retry_limit_reg[COUNT_W-1:0];
    assign product       = next_delay_reg * growth_reg;
    assign grown         = product[DELAY_W+GROWTH_W-1:FRAC_W];
    assign grown_clamped = (grown > {{(GROWTH_W-FRAC_W){1'b0}}, delay_cap_reg})
                           ? delay_cap_reg : grown[DELAY_W-1:0];
    assign wait_dec      = wait_left_reg - 1'b1;

    // The limit check runs on the count before the attempt in question.
    always_comb
    begin
        if (in_kind_reg == KIND_TRIGGER)
        begin
            limit_hit = !unlimited && (limit_count == '0);
        end
        else
        begin
            limit_hit = !unlimited && (attempts_reg >= limit_count);
        end
    end

    always_comb
    begin
        run_active_next = run_active_reg;
        halted_next     = halted_reg;
        awaiting_next   = awaiting_reg;
        attempts_next   = attempts_reg;
        next_delay_next = next_delay_reg;
        wait_left_next  = wait_left_reg;
        out_event_next  = EV_NONE;
        out_wait_next   = '0;
        out_count_next  = attempts_reg;

        case (in_kind_reg)
            KIND_TRIGGER:
            begin
                if (retry_enable_reg && !run_active_reg && !halted_reg)
                begin
                    next_delay_next = first_delay_reg;
                    wait_left_next  = '0;
                    if (limit_hit)
                    begin
                        run_active_next = 1'b0;
                        awaiting_next   = 1'b0;
                        attempts_next   = '0;
                        out_event_next  = EV_GAVE_UP;
                    end
                    else
                    begin
                        run_active_next = 1'b1;
                        awaiting_next   = 1'b1;
                        attempts_next   = COUNT_W'(1);
                        out_event_next  = EV_ATTEMPT;
                    end
                    out_count_next = attempts_next;
                end
            end
            KIND_OUTCOME:
            begin
                if (run_active_reg && !halted_reg && awaiting_reg)
                begin
                    awaiting_next = 1'b0;
                    if (in_ok_reg)
                    begin
                        out_event_next  = EV_SUCCESS;
                        attempts_next   = '0;
                        run_active_next = 1'b0;
                    end
                    else
                    begin
                        out_wait_next   = (next_delay_reg != '0) ? next_delay_reg
                                                                 : DELAY_W'(1);
                        wait_left_next  = out_wait_next;
                        out_event_next  = EV_WAITING;
                        next_delay_next = grown_clamped;
                    end
                end
            end
            KIND_TICK:
            begin
                if (run_active_reg && !halted_reg && (wait_left_reg != '0))
                begin
                    wait_left_next = wait_dec;
                    if (wait_dec == '0)
                    begin
                        if (limit_hit)
                        begin
                            run_active_next = 1'b0;
                            awaiting_next   = 1'b0;
                            out_event_next  = EV_GAVE_UP;
                        end
                        else
                        begin
                            if (attempts_reg != COUNT_MAX)
                            begin
                                attempts_next = attempts_reg + 1'b1;
                            end
                            awaiting_next  = 1'b1;
                            out_event_next = EV_ATTEMPT;
                        end
                        out_count_next = attempts_next;
                    end
                end
            end
            KIND_STOP:
            begin
                halted_next = 1'b1;
            end
            KIND_RESET:
            begin
                run_active_next = 1'b0;
                halted_next     = 1'b0;
                awaiting_next   = 1'b0;
                attempts_next   = '0;
                next_delay_next = '0;
                wait_left_next  = '0;
                out_count_next  = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg <= 1'b0;
            halted_reg     <= 1'b0;
            awaiting_reg   <= 1'b0;
            attempts_reg   <= '0;
            next_delay_reg <= '0;
            wait_left_reg  <= '0;
        end
        else if (advance)
        begin
            run_active_reg <= run_active_next;
            halted_reg     <= halted_next;
            awaiting_reg   <= awaiting_next;
            attempts_reg   <= attempts_next;
            next_delay_reg <= next_delay_next;
            wait_left_reg  <= wait_left_next;
        end
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_event_reg <= out_event_next;
            out_count_reg <= out_count_next;
            out_wait_reg  <= out_wait_next;
            out_busy_reg  <= run_active_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_event_reg;
    assign m_tdata  = {7'd0, out_busy_reg, out_wait_reg, out_count_reg};

    `RBC_ASSERT_IMP(a_await_in_run, awaiting_reg, run_active_reg,
                    "Attempt pending outside of a run.")
    `RBC_ASSERT_IMP(a_wait_in_run, wait_left_reg != '0,
                    run_active_reg && !awaiting_reg,
                    "Backoff wait running without an active run or with an attempt pending.")
    `RBC_ASSERT_IMP(a_waiting_nonzero, out_valid_reg && (out_event_reg == EV_WAITING),
                    (out_wait_reg != '0) && out_busy_reg,
                    "Waiting event reported with zero wait or idle run.")
    `RBC_ASSERT_NXT(a_reset_clears, advance && (in_kind_reg == KIND_RESET),
                    !run_active_reg && !halted_reg && (wait_left_reg == '0),
                    "Reset command did not clear the run state.")

endmodule

@@ test/retry_backoff_controller_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for retry_backoff_controller_core: a directed table checked against
// its own expected results, and randomized register phases checked against a built-in predictor.
// Depends on rbc_pkg and the controller RTL only.
module retry_backoff_controller_core_tb;
    import rbc_pkg::*;

    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam int RANDOM_ITEMS = 1400;

    typedef struct {
        logic        enable;
        logic [16:0] limit;
        logic [31:0] first;
        logic [31:0] cap;
        logic [11:0] growth;
    } settings_t;

    typedef struct {
        event_t      ev;
        logic [15:0] count;
        logic [31:0] wait_len;
        logic        busy;
    } result_t;

    typedef struct {
        bit          reconfig;
        settings_t   regs;
        logic [2:0]  kind;
        logic        ok;
        bit          typed;
        result_t     exp;
    } script_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = 3'd0;
    logic [31:0] cfg_wdata = 32'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // [0] attempt_ok, [7:1] zero
    logic [2:0]  s_tuser = 3'd0;   // [2:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;          // [15:0] attempt_number, [47:16] wait_ms, [48] busy_res
    logic [2:0]  m_tuser;          // [2:0] event_res

    retry_backoff_controller_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Predictor copy of the registers and the run state.
    settings_t   cur;
    logic        run_on;
    logic        frozen;
    logic        awaiting;
    logic [15:0] tries;
    logic [31:0] delay_next;
    logic [31:0] ticks_left;

    result_t owed_results[$];
    int      mismatches = 0;
    int      checked = 0;
    int      sent = 0;
    int      settings_loaded = 0;
    int      random_done = 0;
    int      event_seen[0:4] = '{default: 0};

    int      stall_pct = 0;
    int      stall_max = 0;
    int      hold = 0;
    int      burst_left = 1;
    bit      quiet = 1'b0;
    bit      offering = 1'b0;

    result_t seen;
    result_t want;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(64'd20_000_000);
        $display("Timeout with %0d results still owed.", owed_results.size());
        $display("FAILED: results differ");
        $finish;
    end

    function automatic settings_t mk_settings(input logic en, input logic [16:0] lim,
                                              input logic [31:0] first, input logic [31:0] cap,
                                              input logic [11:0] growth);
        settings_t s;
        s.enable = en;
        s.limit = lim;
        s.first = first;
        s.cap = cap;
        s.growth = growth;
        return s;
    endfunction

    function automatic script_row_t step_row(input logic [2:0] k, input logic ok, input bit typed,
                                             input event_t ev, input logic [15:0] cnt,
                                             input logic [31:0] wl, input logic busy);
        script_row_t r;
        r.reconfig = 1'b0;
        r.regs = cur;
        r.kind = k;
        r.ok = ok;
        r.typed = typed;
        r.exp.ev = ev;
        r.exp.count = cnt;
        r.exp.wait_len = wl;
        r.exp.busy = busy;
        return r;
    endfunction

    function automatic script_row_t cfg_row(input settings_t s);
        script_row_t r;
        r = step_row(KIND_TRIGGER, 1'b0, 1'b0, EV_NONE, 16'd0, 32'd0, 1'b0);
        r.reconfig = 1'b1;
        r.regs = s;
        return r;
    endfunction

    function automatic void clear_run();
        run_on = 1'b0;
        frozen = 1'b0;
        awaiting = 1'b0;
        tries = '0;
        delay_next = '0;
        ticks_left = '0;
    endfunction

    // Limit check before an attempt: either give up or request the attempt.
    function automatic event_t next_attempt();
        if (!cur.limit[16] && tries >= cur.limit[15:0])
        begin
            run_on = 1'b0;
            awaiting = 1'b0;
            return EV_GAVE_UP;
        end
        if (tries != COUNT_MAX)
            tries = tries + 16'd1;
        awaiting = 1'b1;
        return EV_ATTEMPT;
    endfunction

    function automatic result_t backoff_step(input logic [2:0] kind, input logic ok,
                                             output bit acted);
        result_t     r;
        logic [43:0] grown;
        logic [15:0] shown;
        bit          show;
        r.ev = EV_NONE;
        r.wait_len = '0;
        show = 1'b0;
        shown = '0;
        acted = 1'b0;
        case (kind)
            KIND_TRIGGER:
            begin
                if (cur.enable && !run_on && !frozen)
                begin
                    run_on = 1'b1;
                    tries = '0;
                    delay_next = cur.first;
                    ticks_left = '0;
                    r.ev = next_attempt();
                    acted = 1'b1;
                end
            end
            KIND_OUTCOME:
            begin
                if (run_on && !frozen && awaiting)
                begin
                    awaiting = 1'b0;
                    acted = 1'b1;
                    if (ok)
                    begin
                        r.ev = EV_SUCCESS;
                        shown = tries;
                        show = 1'b1;
                        tries = '0;
                        run_on = 1'b0;
                    end
                    else
                    begin
                        r.wait_len = (delay_next != 0) ? delay_next : 32'd1;
                        ticks_left = r.wait_len;
                        r.ev = EV_WAITING;
                        grown = (44'(delay_next) * 44'(cur.growth)) >> FRAC_W;
                        if (grown > 44'(cur.cap))
                            grown = 44'(cur.cap);
                        delay_next = grown[31:0];
                    end
                end
            end
            KIND_TICK:
            begin
                if (run_on && !frozen && ticks_left != 0)
                begin
                    acted = 1'b1;
                    ticks_left = ticks_left - 32'd1;
                    if (ticks_left == 0)
                        r.ev = next_attempt();
                end
            end
            KIND_STOP:
            begin
                frozen = 1'b1;
                acted = 1'b1;
            end
            KIND_RESET:
            begin
                clear_run();
                acted = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.count = show ? shown : tries;
        r.busy = run_on;
        return r;
    endfunction

    task automatic lower_valid();
        if (offering)
        begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic pace();
        if (quiet)
            return;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            lower_valid();
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic drain();
        lower_valid();
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(input settings_t s);
        drain();
        cfg_we <= 1'b1;
        cfg_addr <= CFG_RETRY_ENABLE;
        cfg_wdata <= {31'd0, s.enable};
        @(posedge clk);
        cfg_addr <= CFG_RETRY_LIMIT;
        cfg_wdata <= {15'd0, s.limit};
        @(posedge clk);
        cfg_addr <= CFG_FIRST_DELAY;
        cfg_wdata <= s.first;
        @(posedge clk);
        cfg_addr <= CFG_DELAY_CAP;
        cfg_wdata <= s.cap;
        @(posedge clk);
        cfg_addr <= CFG_GROWTH;
        cfg_wdata <= {20'd0, s.growth};
        @(posedge clk);
        cfg_we <= 1'b0;
        cur = s;
        settings_loaded++;
    endtask

    task automatic push_item(input logic [2:0] k, input logic ok, input bit typed,
                             input result_t exp, output bit acted);
        result_t pred;
        pred = backoff_step(k, ok, acted);
        s_tvalid <= 1'b1;
        s_tuser <= k;
        s_tdata <= {7'd0, ok};
        offering = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        owed_results.push_back(typed ? exp : pred);
        sent++;
        pace();
    endtask

    always @(posedge clk)
    begin
        if (hold > 0)
        begin
            hold <= hold - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            hold <= $urandom_range(0, stall_max);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.ev = event_t'(m_tuser);
            seen.count = m_tdata[15:0];
            seen.wait_len = m_tdata[47:16];
            seen.busy = m_tdata[48];
            if (m_tuser <= 3'd4)
                event_seen[m_tuser]++;
            if (owed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction: event %0d count %0d wait %0d busy %0d",
                             seen.ev, seen.count, seen.wait_len, seen.busy);
            end
            else
            begin
                want = owed_results.pop_front();
                checked++;
                if (seen.ev !== want.ev || seen.count !== want.count ||
                    seen.wait_len !== want.wait_len || seen.busy !== want.busy)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch on result %0d: expected event %0d count %0d wait %0d busy %0d",
                                 checked, want.ev, want.count, want.wait_len, want.busy);
                        $display("    got event %0d count %0d wait %0d busy %0d",
                                 seen.ev, seen.count, seen.wait_len, seen.busy);
                    end
                end
            end
        end
    end

    initial
    begin
        script_row_t script[$];
        settings_t   s;
        result_t     blank;
        logic [2:0]  k;
        logic        ok;
        bit          acted;
        int          r;
        int          n;
        int          raw;
        int          ph;

        blank = '{ev: EV_NONE, count: 16'd0, wait_len: 32'd0, busy: 1'b0};
        cur = mk_settings(RST_RETRY_ENABLE, RST_RETRY_LIMIT, RST_FIRST_DELAY, RST_DELAY_CAP,
                          RST_GROWTH);
        clear_run();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        stall_pct <= 20;
        stall_max <= 6;
        @(posedge clk);

        // Register defaults after reset, then a disabled block and a zero retry limit.
        script.push_back(step_row(KIND_TICK, 1'b0, 1, EV_NONE, 16'd0, 32'd0, 1'b0));
        script.push_back(step_row(KIND_OUTCOME, 1'b1, 1, EV_NONE, 16'd0, 32'd0, 1'b0));
        script.push_back(step_row(KIND_SPARE_LO, 1'b1, 1, EV_NONE, 16'd0, 32'd0, 1'b0));
        script.push_back(step_row(KIND_TRIGGER, 1'b0, 1, EV_ATTEMPT, 16'd1, 32'd0, 1'b1));
        script.push_back(step_row(KIND_TRIGGER, 1'b0, 1, EV_NONE, 16'd1, 32'd0, 1'b1));
        script.push_back(step_row(KIND_OUTCOME, 1'b0, 1, EV_WAITING, 16'd1, 32'd1000, 1'b1));
        script.push_back(step_row(KIND_STOP, 1'b0, 1, EV_NONE, 16'd1, 32'd0, 1'b1));
        script.push_back(step_row(KIND_TICK, 1'b0, 1, EV_NONE, 16'd1, 32'd0, 1'b1));
        script.push_back(step_row(KIND_TRIGGER, 1'b0, 1, EV_NONE, 16'd1, 32'd0, 1'b1));
        script.push_back(step_row(KIND_RESET, 1'b0, 1, EV_NONE, 16'd0, 32'd0, 1'b0));
        script.push_back(cfg_row(mk_settings(1'b0, 17'd5, 32'd1000, 32'd30000, 12'd512)));
        script.push_back(step_row(KIND_TRIGGER, 1'b0, 1, EV_NONE, 16'd0, 32'd0, 1'b0));
        script.push_back(cfg_row(mk_settings(1'b1, 17'd0, 32'd1000, 32'd30000, 12'd512)));
        script.push_back(step_row(KIND_TRIGGER, 1'b0, 1, EV_GAVE_UP, 16'd0, 32'd0, 1'b0));
        // Unlimited retries with a zero delay.
        script.push_back(cfg_row(mk_settings(1'b1, 17'h1FFFF, 32'd0, 32'd30000, 12'd0)));
        script.push_back(step_row(KIND_TRIGGER, 1'b0, 1, EV_ATTEMPT, 16'd1, 32'd0, 1'b1));
        script.push_back(step_row(KIND_OUTCOME, 1'b0, 1, EV_WAITING, 16'd1, 32'd1, 1'b1));
        script.push_back(step_row(KIND_TICK, 1'b1, 1, EV_ATTEMPT, 16'd2, 32'd0, 1'b1));
        script.push_back(step_row(KIND_OUTCOME, 1'b1, 1, EV_SUCCESS, 16'd2, 32'd0, 1'b0));
        // First delay above the cap, then growth clamped to the cap.
        script.push_back(cfg_row(mk_settings(1'b1, 17'd2, 32'd3, 32'd2, 12'd4095)));
        script.push_back(step_row(KIND_TRIGGER, 1'b0, 1, EV_ATTEMPT, 16'd1, 32'd0, 1'b1));
        script.push_back(step_row(KIND_OUTCOME, 1'b0, 1, EV_WAITING, 16'd1, 32'd3, 1'b1));
        script.push_back(step_row(KIND_TICK, 1'b0, 1, EV_NONE, 16'd1, 32'd0, 1'b1));
        script.push_back(step_row(KIND_TICK, 1'b0, 1, EV_NONE, 16'd1, 32'd0, 1'b1));
        script.push_back(step_row(KIND_TICK, 1'b0, 1, EV_ATTEMPT, 16'd2, 32'd0, 1'b1));
        script.push_back(step_row(KIND_OUTCOME, 1'b0, 0, EV_NONE, 16'd0, 32'd0, 1'b0));
        script.push_back(step_row(KIND_TICK, 1'b0, 0, EV_NONE, 16'd0, 32'd0, 1'b0));
        script.push_back(step_row(KIND_TICK, 1'b0, 0, EV_NONE, 16'd0, 32'd0, 1'b0));
        // Largest delay and growth: the product is wider than the delay register.
        script.push_back(cfg_row(mk_settings(1'b1, 17'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                             12'd4095)));
        script.push_back(step_row(KIND_TRIGGER, 1'b0, 1, EV_ATTEMPT, 16'd1, 32'd0, 1'b1));
        script.push_back(step_row(KIND_OUTCOME, 1'b0, 1, EV_WAITING, 16'd1, 32'hFFFF_FFFF,
                                  1'b1));
        script.push_back(step_row(KIND_OUTCOME, 1'b0, 0, EV_NONE, 16'd0, 32'd0, 1'b0));
        script.push_back(step_row(KIND_RESET, 1'b1, 1, EV_NONE, 16'd0, 32'd0, 1'b0));

        foreach (script[i])
        begin
            if (script[i].reconfig)
                load_settings(script[i].regs);
            else
                push_item(script[i].kind, script[i].ok, script[i].typed, script[i].exp, acted);
        end

        ph = 0;
        while (random_done < RANDOM_ITEMS)
        begin
            if (ph == 0)
                s = mk_settings(1'b1, 17'd1, 32'd0, 32'd0, 12'd0);
            else if (ph == 1)
                s = mk_settings(1'b1, 17'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd4095);
            else
            begin
                s.enable = (ph == 2) ? 1'b0 : ($urandom_range(0, 4) != 0);
                case ($urandom_range(0, 5))
                    0: s.limit = 17'h1FFFF;
                    1: s.limit = {1'b1, 16'($urandom)};
                    2: s.limit = 17'd0;
                    3: s.limit = 17'd65535;
                    default: s.limit = 17'($urandom_range(1, 8));
                endcase
                s.first = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 6));
                s.cap = ($urandom_range(0, 5) == 0) ? $urandom : 32'($urandom_range(0, 24));
                case ($urandom_range(0, 5))
                    0: s.growth = 12'd0;
                    1: s.growth = 12'd256;
                    2: s.growth = 12'd4095;
                    default: s.growth = 12'($urandom_range(0, 4095));
                endcase
            end
            load_settings(s);
            quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 2);
            stall_pct <= (r == 0) ? 0 : ((r == 1) ? 10 : 40);
            stall_max <= $urandom_range(0, 20);

            n = 0;
            raw = 0;
            while (n < 120 && raw < 300 && random_done < RANDOM_ITEMS)
            begin
                r = $urandom_range(0, 99);
                ok = $urandom_range(0, 1);
                if (r < 8)
                    k = 3'($urandom_range(0, 7));
                else if (r < 10)
                    k = KIND_STOP;
                else if (frozen)
                    k = (r < 60) ? KIND_RESET : 3'($urandom_range(0, 2));
                else if (!run_on)
                    k = KIND_TRIGGER;
                else if (awaiting)
                begin
                    k = KIND_OUTCOME;
                    ok = ($urandom_range(0, 3) == 0);
                end
                else if (ticks_left > 64)
                    k = KIND_RESET;
                else
                    k = KIND_TICK;
                push_item(k, ok, 0, blank, acted);
                raw++;
                if (acted)
                begin
                    n++;
                    random_done++;
                end
                if ($urandom_range(0, 199) == 0)
                    drain();
            end
            ph++;
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Sent %0d transactions over %0d register settings; %0d results checked.",
                 sent, settings_loaded, checked);
        $display("Attempts %0d, successes %0d, give-ups %0d, waits %0d, no-event %0d.",
                 event_seen[1], event_seen[2], event_seen[3], event_seen[4], event_seen[0]);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("PASSED: all results match");
        else
        begin
            $display("%0d mismatches, %0d results never arrived.", mismatches,
                     owed_results.size());
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+design
design/rbc_pkg.sv
design/retry_backoff_controller_core.sv
test/retry_backoff_controller_core_tb.sv
